@@ rtl/core/fcsg_pkg.sv @@
// Shared widths, constants and the sequencer state type of the circle span generator.
package fcsg_pkg;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int RADIUS_W = 5;
    // The square under the root never exceeds 31 * 31, so ten bits hold it.
    localparam int VALUE_W  = 2 * RADIUS_W;
    localparam int ROOT_W   = RADIUS_W;

    localparam int ROWS_DEFAULT = 64;
    localparam int COLS_DEFAULT = 128;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(10);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_EMIT,
        S_FLUSH
    } t_state;

endpackage

@@ rtl/core/fcsg_isqrt.sv @@
// Iterative integer square root, one result bit per cycle, for the circle span generator.
module fcsg_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fcsg_pkg::VALUE_W-1:0]     i_value,
    output logic                             o_done,
    output logic [fcsg_pkg::ROOT_W-1:0]      o_root
);

    logic                            r_busy;
    logic                            r_done;
    logic [fcsg_pkg::VALUE_W-1:0]    r_value;
    logic [fcsg_pkg::ROOT_W-1:0]     r_root;
    logic [fcsg_pkg::ROOT_W-1:0]     r_mask;
    logic [fcsg_pkg::ROOT_W-1:0]     trial;
    logic [fcsg_pkg::VALUE_W-1:0]    trial_sq;

    assign trial    = r_root | r_mask;
    assign trial_sq = fcsg_pkg::VALUE_W'(trial) * fcsg_pkg::VALUE_W'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_mask[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Restoring square root: keep each trial bit whose square still fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
            r_root  <= '0;
            r_mask  <= {1'b1, {(fcsg_pkg::ROOT_W-1){1'b0}}};
        end else if (r_busy) begin
            if (trial_sq <= r_value) begin
                r_root <= trial;
            end
            r_mask <= r_mask >> 1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_busy_done_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("square root unit reports done while still busy");

    a_root_not_too_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((fcsg_pkg::VALUE_W+1)'(r_root) * (fcsg_pkg::VALUE_W+1)'(r_root)
                    <= (fcsg_pkg::VALUE_W+1)'(r_value)))
        else $error("square root result squared exceeds its operand");

    a_root_not_too_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (((fcsg_pkg::VALUE_W+1)'(r_root) + 1'b1)
                    * ((fcsg_pkg::VALUE_W+1)'(r_root) + 1'b1)
                    > (fcsg_pkg::VALUE_W+1)'(r_value)))
        else $error("square root result is below the floor root");

endmodule

@@ rtl/core/filled_circle_span_generator_core.sv @@
// Top level of the filled circle span generator: sequencer, span clipping and output words.
//
// Each accepted centre word walks the row offsets from -radius to radius-1 and, for every row
// inside the grid, takes the floor square root of radius^2 - offset^2 in a shared bit-serial
// root unit that produces one result bit per cycle. A row inside the grid passes through
// set-up, five root steps, a hand-over and a span check, and a row off the grid only through
// its check against the grid; the span check waits while a held span cannot go to a stalled
// output word. The input is stalled while a circle is in progress. One span is held back so
// that the final span of a circle can be marked as last; an output word that is waiting does
// not stop the next circle from being accepted. The radius register may be written at any
// time and is sampled when a centre word is accepted.
module filled_circle_span_generator_core #(
    parameter int ROWS = fcsg_pkg::ROWS_DEFAULT,
    parameter int COLS = fcsg_pkg::COLS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // centre words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fcsg_pkg::ROW_W-1:0]        i_center_row,
    input  logic [fcsg_pkg::COL_W-1:0]        i_center_col,
    // span words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fcsg_pkg::ROW_W-1:0]        o_span_row,
    output logic [fcsg_pkg::COL_W-1:0]        o_col_first,
    output logic [fcsg_pkg::COL_W-1:0]        o_col_last,
    output logic                              o_last_span,
    // radius register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fcsg_pkg::RADIUS_W-1:0]     i_cfg_radius
);

    localparam int RW = fcsg_pkg::ROW_W;
    localparam int CW = fcsg_pkg::COL_W;
    localparam int AW = fcsg_pkg::RADIUS_W;
    localparam int VW = fcsg_pkg::VALUE_W;
    localparam int HW = fcsg_pkg::ROOT_W;
    // Signed widths wide enough for centre plus or minus radius.
    localparam int SRW = RW + 2;
    localparam int SCW = CW + 2;
    localparam int DW  = AW + 1;
    localparam logic signed [SRW-1:0] ROWS_S     = SRW'(ROWS);
    localparam logic signed [SCW-1:0] COLS_MAX_S = SCW'(COLS - 1);

    fcsg_pkg::t_state          r_state, n_state;
    logic [AW-1:0]             r_radius;
    logic [AW-1:0]             r_rad, n_rad;
    logic [VW-1:0]             r_rsq, n_rsq;
    logic signed [DW-1:0]      r_d, n_d;
    logic [RW-1:0]             r_crow, n_crow;
    logic [CW-1:0]             r_ccol, n_ccol;

    logic                      r_pend_valid, n_pend_valid;
    logic [RW-1:0]             r_pend_row, n_pend_row;
    logic [CW-1:0]             r_pend_first, n_pend_first;
    logic [CW-1:0]             r_pend_last, n_pend_last;

    logic                      r_out_valid, n_out_valid;
    logic [RW-1:0]             r_out_row, n_out_row;
    logic [CW-1:0]             r_out_first, n_out_first;
    logic [CW-1:0]             r_out_last, n_out_last;
    logic                      r_out_flag, n_out_flag;

    logic                      in_accept;
    logic                      out_free;
    logic signed [SRW-1:0]     row_s;
    logic                      row_ok;
    logic [AW-1:0]             abs_d;
    logic [VW-1:0]             d_sq;
    logic                      root_start;
    logic                      root_done;
    logic [HW-1:0]             root;
    logic signed [SCW-1:0]     first_raw, last_raw, first_clip, last_clip;
    logic                      span_ok;
    logic signed [DW-1:0]      d_next;
    logic                      walk_end;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != fcsg_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign row_s  = SRW'($signed({1'b0, r_crow})) + SRW'(r_d);
    assign row_ok = (row_s >= 0) && (row_s < ROWS_S);
    assign abs_d  = r_d[DW-1] ? AW'(-r_d) : AW'(r_d);
    assign d_sq   = VW'(abs_d) * VW'(abs_d);

    assign first_raw  = SCW'($signed({1'b0, r_ccol})) - SCW'($signed({1'b0, root}));
    assign last_raw   = SCW'($signed({1'b0, r_ccol})) + SCW'($signed({1'b0, root})) - SCW'(1);
    assign first_clip = (first_raw < 0) ? '0 : first_raw;
    assign last_clip  = (last_raw > COLS_MAX_S) ? COLS_MAX_S : last_raw;
    assign span_ok    = (root != '0) && (first_clip <= last_clip);

    assign d_next   = r_d + DW'(1);
    assign walk_end = (d_next == $signed({1'b0, r_rad}));

    fcsg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (r_rsq - d_sq),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fcsg_pkg::S_IDLE;
            r_radius     <= fcsg_pkg::RADIUS_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_radius;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad        <= n_rad;
        r_rsq        <= n_rsq;
        r_d          <= n_d;
        r_crow       <= n_crow;
        r_ccol       <= n_ccol;
        r_pend_row   <= n_pend_row;
        r_pend_first <= n_pend_first;
        r_pend_last  <= n_pend_last;
        r_out_row    <= n_out_row;
        r_out_first  <= n_out_first;
        r_out_last   <= n_out_last;
        r_out_flag   <= n_out_flag;
    end

    always_comb begin
        n_state      = r_state;
        n_rad        = r_rad;
        n_rsq        = r_rsq;
        n_d          = r_d;
        n_crow       = r_crow;
        n_ccol       = r_ccol;
        n_pend_valid = r_pend_valid;
        n_pend_row   = r_pend_row;
        n_pend_first = r_pend_first;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_row    = r_out_row;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;
        n_out_flag   = r_out_flag;
        root_start   = 1'b0;

        case (r_state)
            fcsg_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_rad        = r_radius;
                    n_rsq        = VW'(r_radius) * VW'(r_radius);
                    n_d          = -$signed({1'b0, r_radius});
                    n_crow       = i_center_row;
                    n_ccol       = i_center_col;
                    n_pend_valid = 1'b0;
                    n_state      = (r_radius == '0) ? fcsg_pkg::S_FLUSH : fcsg_pkg::S_SQUARE;
                end
            end
            fcsg_pkg::S_SQUARE: begin
                // Rows off the grid skip the root entirely.
                if (row_ok) begin
                    root_start = 1'b1;
                    n_state    = fcsg_pkg::S_ROOT;
                end else begin
                    n_d     = d_next;
                    n_state = walk_end ? fcsg_pkg::S_FLUSH : fcsg_pkg::S_SQUARE;
                end
            end
            fcsg_pkg::S_ROOT: begin
                if (root_done) begin
                    n_state = fcsg_pkg::S_EMIT;
                end
            end
            fcsg_pkg::S_EMIT: begin
                // A new span pushes the held one out, which therefore cannot be the last.
                if (!span_ok || !r_pend_valid || out_free) begin
                    if (span_ok) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_row   = r_pend_row;
                            n_out_first = r_pend_first;
                            n_out_last  = r_pend_last;
                            n_out_flag  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_row   = row_s[RW-1:0];
                        n_pend_first = first_clip[CW-1:0];
                        n_pend_last  = last_clip[CW-1:0];
                    end
                    n_d     = d_next;
                    n_state = walk_end ? fcsg_pkg::S_FLUSH : fcsg_pkg::S_SQUARE;
                end
            end
            fcsg_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = fcsg_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_pend_row;
                    n_out_first  = r_pend_first;
                    n_out_last   = r_pend_last;
                    n_out_flag   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = fcsg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcsg_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_span_row  = r_out_row;
    assign o_col_first = r_out_first;
    assign o_col_last  = r_out_last;
    assign o_last_span = r_out_flag;

    a_root_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == fcsg_pkg::S_ROOT))
        else $error("root result arrived outside the wait state");

    a_idle_has_no_held_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcsg_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("a held span was left behind at the end of a circle");

    a_span_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_first <= r_out_last))
        else $error("output span has its first column beyond its last");

endmodule
